// ----- rtl/kcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// kcsc_pkg
// Shared types, codes and constants for the kicker charge/shoot controller.
// ----------------------------------------------------------------------------
package kcsc_pkg;

  // Controller phase, as reported in the result
  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_READY    = 2'd1,
    PH_CHARGING = 2'd2,
    PH_SHOOTING = 2'd3
  } phase_t;

  // Event kinds on s_tuser
  typedef enum logic [1:0] {
    FN_CALLBACK = 2'd0,
    FN_START    = 2'd1,
    FN_DISABLE  = 2'd2,
    FN_SHOOT    = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SQUARE,
    SQ_SUM,
    SQ_SCALE,
    SQ_COMMIT
  } seq_t;

  // Configuration register indexes
  localparam logic [3:0] REG_MIN_SHOOT_V   = 4'd0;
  localparam logic [3:0] REG_RECHARGE_V    = 4'd1;
  localparam logic [3:0] REG_MIN_SPEED     = 4'd2;
  localparam logic [3:0] REG_MAX_SPEED     = 4'd3;
  localparam logic [3:0] REG_READY_PER     = 4'd4;
  localparam logic [3:0] REG_CHARGING_PER  = 4'd5;
  localparam logic [3:0] REG_SHOOTING_PER  = 4'd6;
  localparam logic [3:0] REG_OFF_PER       = 4'd7;

  // Register reset values
  localparam logic [11:0] RST_MIN_SHOOT_V = 12'd400;
  localparam logic [11:0] RST_RECHARGE_V  = 12'd2200;
  localparam logic [11:0] RST_MIN_SPEED   = 12'd256;
  localparam logic [11:0] RST_MAX_SPEED   = 12'd1664;
  localparam logic [15:0] RST_PERIOD      = 16'd1000;

  localparam logic [31:0] READY_TIMEOUT_MS = 32'd15000;

  // t = (675*S^2 + 871424*S + 705101824) / 655360, S in Q4.8
  localparam logic [9:0]  PULSE_A = 10'd675;
  localparam logic [19:0] PULSE_B = 20'd871424;
  localparam logic [33:0] PULSE_C = 34'd705101824;
  // divide by 10 after the >>16: x*ceil(2^22/10) >> 22, exact for x < 2^19
  localparam logic [18:0] DIV10_MUL = 19'd419431;

  typedef struct packed {
    logic load;
    logic square;
    logic sum;
    logic scale;
    logic commit;
  } kcsc_cmd_t;

  typedef struct packed {
    logic out_full;
  } kcsc_status_t;

endpackage

// ----- rtl/kcsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcsc_ctrl
// Sequencer: takes one event, walks the pulse-time stages, then commits the
// event once the output register can take the result.
// ----------------------------------------------------------------------------
module kcsc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  kcsc_pkg::kcsc_status_t status,
  output kcsc_pkg::kcsc_cmd_t    cmd
);

  kcsc_pkg::seq_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcsc_pkg::SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      kcsc_pkg::SQ_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = kcsc_pkg::SQ_SQUARE;
        end
      end
      kcsc_pkg::SQ_SQUARE: begin
        cmd.square = 1'b1;
        state_next = kcsc_pkg::SQ_SUM;
      end
      kcsc_pkg::SQ_SUM: begin
        cmd.sum    = 1'b1;
        state_next = kcsc_pkg::SQ_SCALE;
      end
      kcsc_pkg::SQ_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = kcsc_pkg::SQ_COMMIT;
      end
      kcsc_pkg::SQ_COMMIT: begin
        if (!status.out_full) begin
          cmd.commit = 1'b1;
          state_next = kcsc_pkg::SQ_IDLE;
        end
      end
      default: state_next = kcsc_pkg::SQ_IDLE;
    endcase
  end

endmodule

// ----- rtl/kcsc_dp.sv -----
// ----------------------------------------------------------------------------
// kcsc_dp
// Datapath: config registers, controller state, pulse-time arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module kcsc_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  kcsc_pkg::kcsc_cmd_t    cmd,
  output kcsc_pkg::kcsc_status_t status,
  input  logic                  cfg_valid,
  input  logic [3:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [59:0]           s_tdata,
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata
);

  // config
  logic [11:0] min_shoot_voltage, recharge_voltage, min_speed, max_speed;
  logic [15:0] ready_period, charging_period, shooting_period, off_period;

  // controller state
  kcsc_pkg::phase_t phase_reg, phase_next;
  logic        charged_flag, charged_next;
  logic        fault_flag, fault_next;
  logic        charge_allowed, allowed_next;
  logic [31:0] ready_since_ms, since_next;
  logic [2:0]  drive_pins, pins_next;   // bit0 kick, bit1 chip, bit2 charge

  // captured event
  kcsc_pkg::func_t func_q;
  logic [31:0] now_q;
  logic [11:0] volt_q;
  logic        sensor_q, fault_n_q, done_n_q, kind_q;
  logic [11:0] speed_q;

  // pulse-time pipeline
  logic [23:0] sq;
  logic [31:0] lin;
  logic [33:0] num;
  logic [36:0] prod;
  logic [15:0] pulse_us;

  logic [11:0] spd_lo, spd_clamped;
  logic        rvalid;
  logic [15:0] rperiod;
  logic [31:0] limit;
  logic        by_volt, by_time;

  // raise to min first, then lower to max: max wins on a crossed pair
  always_comb begin
    spd_lo      = (s_tdata[59:48] < min_speed) ? min_speed : s_tdata[59:48];
    spd_clamped = (max_speed < spd_lo) ? max_speed : spd_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_shoot_voltage <= kcsc_pkg::RST_MIN_SHOOT_V;
      recharge_voltage  <= kcsc_pkg::RST_RECHARGE_V;
      min_speed         <= kcsc_pkg::RST_MIN_SPEED;
      max_speed         <= kcsc_pkg::RST_MAX_SPEED;
      ready_period      <= kcsc_pkg::RST_PERIOD;
      charging_period   <= kcsc_pkg::RST_PERIOD;
      shooting_period   <= kcsc_pkg::RST_PERIOD;
      off_period        <= kcsc_pkg::RST_PERIOD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kcsc_pkg::REG_MIN_SHOOT_V:  min_shoot_voltage <= cfg_data[11:0];
        kcsc_pkg::REG_RECHARGE_V:   recharge_voltage  <= cfg_data[11:0];
        kcsc_pkg::REG_MIN_SPEED:    min_speed         <= cfg_data[11:0];
        kcsc_pkg::REG_MAX_SPEED:    max_speed         <= cfg_data[11:0];
        kcsc_pkg::REG_READY_PER:    ready_period      <= cfg_data;
        kcsc_pkg::REG_CHARGING_PER: charging_period   <= cfg_data;
        kcsc_pkg::REG_SHOOTING_PER: shooting_period   <= cfg_data;
        kcsc_pkg::REG_OFF_PER:      off_period        <= cfg_data;
        default: ;
      endcase
    end
  end

  // event capture and arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= kcsc_pkg::func_t'(s_tuser);
      now_q     <= s_tdata[31:0];
      volt_q    <= s_tdata[43:32];
      sensor_q  <= s_tdata[44];
      fault_n_q <= s_tdata[45];
      done_n_q  <= s_tdata[46];
      kind_q    <= s_tdata[47];
      speed_q   <= spd_clamped;
    end
    if (cmd.square) begin
      sq  <= 24'(speed_q) * 24'(speed_q);
      lin <= 32'(kcsc_pkg::PULSE_B) * 32'(speed_q);
    end
    if (cmd.sum) begin
      num <= 34'(kcsc_pkg::PULSE_A) * 34'(sq) + 34'(lin) + kcsc_pkg::PULSE_C;
    end
    if (cmd.scale) begin
      prod <= 37'(num[33:16]) * 37'(kcsc_pkg::DIV10_MUL);
    end
  end

  // 12-bit speeds stay far below 65535 us, so no saturation is needed
  assign pulse_us = 16'(prod[36:22]);

  assign limit   = ready_since_ms + kcsc_pkg::READY_TIMEOUT_MS;
  assign by_volt = sensor_q && (volt_q >= min_shoot_voltage) && (volt_q <= recharge_voltage);
  assign by_time = !sensor_q && (now_q >= limit);

  always_comb begin
    phase_next   = phase_reg;
    charged_next = charged_flag;
    fault_next   = fault_flag;
    allowed_next = charge_allowed;
    since_next   = ready_since_ms;
    pins_next    = drive_pins;
    rvalid       = 1'b0;
    rperiod      = '0;
    unique case (func_q)
      kcsc_pkg::FN_CALLBACK: begin
        if (!fault_n_q) fault_next = 1'b1;
        rvalid = 1'b1;
        unique case (phase_reg)
          kcsc_pkg::PH_READY: begin
            if (by_volt || by_time) begin
              phase_next   = kcsc_pkg::PH_CHARGING;
              charged_next = 1'b0;
            end
            rperiod = ready_period;
          end
          kcsc_pkg::PH_CHARGING: begin
            if (!done_n_q) begin
              phase_next   = kcsc_pkg::PH_READY;
              charged_next = 1'b1;
              since_next   = now_q;
              pins_next[2] = 1'b0;
            end else begin
              pins_next[2] = 1'b1;
            end
            rperiod = charging_period;
          end
          kcsc_pkg::PH_SHOOTING: begin
            pins_next[1:0] = 2'b00;
            if (charge_allowed) begin
              phase_next   = kcsc_pkg::PH_CHARGING;
              charged_next = 1'b0;
            end else begin
              phase_next   = kcsc_pkg::PH_OFF;
              charged_next = sensor_q && (volt_q >= min_shoot_voltage);
            end
            rperiod = shooting_period;
          end
          kcsc_pkg::PH_OFF: begin
            pins_next = 3'b000;
            rperiod   = off_period;
          end
          default: ;
        endcase
      end
      kcsc_pkg::FN_START: begin
        phase_next   = kcsc_pkg::PH_CHARGING;
        allowed_next = 1'b1;
      end
      kcsc_pkg::FN_DISABLE: begin
        allowed_next = 1'b0;
        if (phase_reg == kcsc_pkg::PH_CHARGING) phase_next = kcsc_pkg::PH_READY;
      end
      kcsc_pkg::FN_SHOOT: begin
        if (phase_reg == kcsc_pkg::PH_READY || phase_reg == kcsc_pkg::PH_OFF) begin
          phase_next   = kcsc_pkg::PH_SHOOTING;
          pins_next[2] = 1'b0;
          if (kind_q) pins_next[1] = 1'b1;
          else        pins_next[0] = 1'b1;
          rvalid  = 1'b1;
          rperiod = pulse_us;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= kcsc_pkg::PH_OFF;
      charged_flag   <= 1'b0;
      fault_flag     <= 1'b0;
      charge_allowed <= 1'b0;
      ready_since_ms <= '0;
      drive_pins     <= '0;
    end else if (cmd.commit) begin
      phase_reg      <= phase_next;
      charged_flag   <= charged_next;
      fault_flag     <= fault_next;
      charge_allowed <= allowed_next;
      ready_since_ms <= since_next;
      drive_pins     <= pins_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {rperiod, rvalid, pins_next[2], pins_next[1], pins_next[0],
                  fault_next, charged_next, phase_next};
    end
  end

  assign status.out_full = m_tvalid && !m_tready;

endmodule

// ----- rtl/kicker_charge_shoot_controller_unit.sv -----
// ----------------------------------------------------------------------------
// kicker_charge_shoot_controller_unit
// Kicker capacitor charge and shoot controller: one result per event.
// ----------------------------------------------------------------------------
// The sequencer steps through load, the square, sum and scale stages, and the commit;
//   the result is registered at the commit, which waits while the output is full.
//   A new event is taken only after the last one has been committed.
// A waiting result does not block the next input transfer.
// Reset (rst, synchronous): config to defaults, phase off, flags and drives
//   cleared, no result pending.
module kicker_charge_shoot_controller_unit (
  input  logic        clk,
  input  logic        rst,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], cap_voltage[43:32], sensor_ok[44], fault_n[45],
  // charge_done_n[46], shot_kind[47], ball_speed[59:48], zero pad[63:60]
  input  logic [63:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // phase[1:0], charged[2], fault[3], kick_drive[4], chip_drive[5],
  // charge_drive[6], reload_valid[7], reload_period[23:8]
  output logic [23:0] m_tdata,
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  kcsc_pkg::kcsc_cmd_t    cmd;
  kcsc_pkg::kcsc_status_t status;

  assign cfg_ready = 1'b1;

  kcsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kcsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata[59:0]),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTH
  // one event in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an event is in flight");

  // a commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("result overwritten");

  // the charger is never driven while shooting
  a_no_charge_in_shot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == kcsc_pkg::PH_SHOOTING) |-> !m_tdata[6])
    else $error("charge drive on in shooting phase");
`endif

endmodule

// ----- tb/kicker_charge_shoot_controller_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kicker_charge_shoot_controller_unit_test
// Drives charge, shoot and timer events into the kicker controller and checks
// every status result against an in-bench model of the phase logic, the pin
// drives and the pulse-length arithmetic, across several register settings
// and with random gaps and backpressure on both streams.
// ----------------------------------------------------------------------------
module kicker_charge_shoot_controller_unit_test;

  typedef struct packed {
    kcsc_pkg::func_t func;
    logic [31:0] now_ms;
    logic [11:0] cap_voltage;
    logic        sensor_ok;
    logic        fault_n;
    logic        charge_done_n;
    logic        shot_kind;
    logic [11:0] ball_speed;
  } kick_event_t;

  // same bit order as m_tdata
  typedef struct packed {
    logic [15:0] reload_period;
    logic        reload_valid;
    logic        charge_drive;
    logic        chip_drive;
    logic        kick_drive;
    logic        fault;
    logic        charged;
    kcsc_pkg::phase_t phase;
  } kicker_result_t;

  typedef logic [7:0][15:0] reg_set_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // model copy of the registers
  logic [11:0] lim_min_shoot = kcsc_pkg::RST_MIN_SHOOT_V;
  logic [11:0] lim_recharge  = kcsc_pkg::RST_RECHARGE_V;
  logic [11:0] lim_min_speed = kcsc_pkg::RST_MIN_SPEED;
  logic [11:0] lim_max_speed = kcsc_pkg::RST_MAX_SPEED;
  logic [15:0] per_ready     = kcsc_pkg::RST_PERIOD;
  logic [15:0] per_charging  = kcsc_pkg::RST_PERIOD;
  logic [15:0] per_shooting  = kcsc_pkg::RST_PERIOD;
  logic [15:0] per_off       = kcsc_pkg::RST_PERIOD;

  // model copy of the controller state
  kcsc_pkg::phase_t mdl_phase  = kcsc_pkg::PH_OFF;
  logic        mdl_charged     = 1'b0;
  logic        mdl_fault       = 1'b0;
  logic        mdl_allow       = 1'b0;
  logic [31:0] mdl_ready_since = '0;
  logic        mdl_kick        = 1'b0;
  logic        mdl_chip        = 1'b0;
  logic        mdl_charge      = 1'b0;

  kicker_result_t pending_kicker_results[$];
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          error_count = 0;
  int          result_index = 0;
  logic [31:0] clock_ms = '0;

  kicker_charge_shoot_controller_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Next status the controller should report for one event.
  function automatic kicker_result_t predict_kicker_result(input kick_event_t ev);
    kicker_result_t  r;
    longint unsigned spd;
    longint unsigned pulse;
    logic [31:0]     ready_deadline;
    r.reload_valid  = 1'b0;
    r.reload_period = '0;
    case (ev.func)
      kcsc_pkg::FN_CALLBACK: begin
        if (!ev.fault_n) mdl_fault = 1'b1;
        r.reload_valid = 1'b1;
        case (mdl_phase)
          kcsc_pkg::PH_READY: begin
            // wraps at 2^32
            ready_deadline = mdl_ready_since + kcsc_pkg::READY_TIMEOUT_MS;
            if ((ev.sensor_ok && ev.cap_voltage >= lim_min_shoot &&
                 ev.cap_voltage <= lim_recharge) ||
                (!ev.sensor_ok && ev.now_ms >= ready_deadline)) begin
              mdl_phase   = kcsc_pkg::PH_CHARGING;
              mdl_charged = 1'b0;
            end
            r.reload_period = per_ready;
          end
          kcsc_pkg::PH_CHARGING: begin
            if (!ev.charge_done_n) begin
              mdl_phase       = kcsc_pkg::PH_READY;
              mdl_charged     = 1'b1;
              mdl_ready_since = ev.now_ms;
              mdl_charge      = 1'b0;
            end else begin
              mdl_charge = 1'b1;
            end
            r.reload_period = per_charging;
          end
          kcsc_pkg::PH_SHOOTING: begin
            mdl_kick = 1'b0;
            mdl_chip = 1'b0;
            if (mdl_allow) begin
              mdl_phase   = kcsc_pkg::PH_CHARGING;
              mdl_charged = 1'b0;
            end else begin
              mdl_phase   = kcsc_pkg::PH_OFF;
              mdl_charged = ev.sensor_ok && (ev.cap_voltage >= lim_min_shoot);
            end
            r.reload_period = per_shooting;
          end
          default: begin
            mdl_kick   = 1'b0;
            mdl_chip   = 1'b0;
            mdl_charge = 1'b0;
            r.reload_period = per_off;
          end
        endcase
      end
      kcsc_pkg::FN_START: begin
        mdl_phase = kcsc_pkg::PH_CHARGING;
        mdl_allow = 1'b1;
      end
      kcsc_pkg::FN_DISABLE: begin
        mdl_allow = 1'b0;
        if (mdl_phase == kcsc_pkg::PH_CHARGING) mdl_phase = kcsc_pkg::PH_READY;
      end
      default: begin
        if (mdl_phase == kcsc_pkg::PH_READY || mdl_phase == kcsc_pkg::PH_OFF) begin
          mdl_phase  = kcsc_pkg::PH_SHOOTING;
          mdl_charge = 1'b0;
          if (ev.shot_kind) mdl_chip = 1'b1;
          else mdl_kick = 1'b1;
          // clamp up first, then down: max wins when the limits cross
          spd = ev.ball_speed;
          if (spd < lim_min_speed) spd = lim_min_speed;
          if (lim_max_speed < spd) spd = lim_max_speed;
          pulse = (64'd675 * spd * spd + 64'd871424 * spd + 64'd705101824) / 64'd655360;
          if (pulse > 64'hFFFF) pulse = 64'hFFFF;
          r.reload_valid  = 1'b1;
          r.reload_period = pulse[15:0];
        end
      end
    endcase
    r.phase        = mdl_phase;
    r.charged      = mdl_charged;
    r.fault        = mdl_fault;
    r.kick_drive   = mdl_kick;
    r.chip_drive   = mdl_chip;
    r.charge_drive = mdl_charge;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("result %0d: %s mismatch, got %0d expected %0d", result_index, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    kicker_result_t got;
    kicker_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_kicker_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = pending_kicker_results.pop_front();
        if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
        if (got.charged !== want.charged)
          report_mismatch("charged", got.charged, want.charged);
        if (got.fault !== want.fault) report_mismatch("fault", got.fault, want.fault);
        if (got.kick_drive !== want.kick_drive)
          report_mismatch("kick_drive", got.kick_drive, want.kick_drive);
        if (got.chip_drive !== want.chip_drive)
          report_mismatch("chip_drive", got.chip_drive, want.chip_drive);
        if (got.charge_drive !== want.charge_drive)
          report_mismatch("charge_drive", got.charge_drive, want.charge_drive);
        if (got.reload_valid !== want.reload_valid)
          report_mismatch("reload_valid", got.reload_valid, want.reload_valid);
        if (got.reload_period !== want.reload_period)
          report_mismatch("reload_period", got.reload_period, want.reload_period);
      end
      result_index++;
    end
  end

  // Caller is at a rising edge; returns at the edge of the transfer.
  task automatic send_event(input kick_event_t ev);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.func;
    s_tdata  <= {4'h0, ev.ball_speed, ev.shot_kind, ev.charge_done_n, ev.fault_n,
                 ev.sensor_ok, ev.cap_voltage, ev.now_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_kicker_results.push_back(predict_kicker_result(ev));
  endtask

  task automatic do_callback(input logic [31:0] now, input logic [11:0] volt,
                             input logic sensor, input logic fault_n, input logic done_n);
    kick_event_t ev;
    ev.func          = kcsc_pkg::FN_CALLBACK;
    ev.now_ms        = now;
    ev.cap_voltage   = volt;
    ev.sensor_ok     = sensor;
    ev.fault_n       = fault_n;
    ev.charge_done_n = done_n;
    ev.shot_kind     = 1'($urandom());
    ev.ball_speed    = 12'($urandom());
    send_event(ev);
  endtask

  task automatic do_command(input kcsc_pkg::func_t f, input logic kind,
                            input logic [11:0] speed);
    kick_event_t ev;
    ev.func          = f;
    ev.now_ms        = $urandom();
    ev.cap_voltage   = 12'($urandom());
    ev.sensor_ok     = 1'($urandom());
    ev.fault_n       = 1'($urandom());
    ev.charge_done_n = 1'($urandom());
    ev.shot_kind     = kind;
    ev.ball_speed    = speed;
    send_event(ev);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_kicker_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      kcsc_pkg::REG_MIN_SHOOT_V:  lim_min_shoot = val[11:0];
      kcsc_pkg::REG_RECHARGE_V:   lim_recharge  = val[11:0];
      kcsc_pkg::REG_MIN_SPEED:    lim_min_speed = val[11:0];
      kcsc_pkg::REG_MAX_SPEED:    lim_max_speed = val[11:0];
      kcsc_pkg::REG_READY_PER:    per_ready     = val;
      kcsc_pkg::REG_CHARGING_PER: per_charging  = val;
      kcsc_pkg::REG_SHOOTING_PER: per_shooting  = val;
      kcsc_pkg::REG_OFF_PER:      per_off       = val;
      default: ;
    endcase
  endtask

  // Writes all eight registers plus one index past the end, which must be dropped.
  task automatic apply_settings(input reg_set_t regs);
    wait_drained();
    for (int i = 0; i < 8; i++) write_reg(4'(i), regs[i]);
    write_reg(4'($urandom_range(15, 8)), 16'($urandom()));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic reg_set_t default_settings();
    reg_set_t regs;
    regs[kcsc_pkg::REG_MIN_SHOOT_V]  = 16'(kcsc_pkg::RST_MIN_SHOOT_V);
    regs[kcsc_pkg::REG_RECHARGE_V]   = 16'(kcsc_pkg::RST_RECHARGE_V);
    regs[kcsc_pkg::REG_MIN_SPEED]    = 16'(kcsc_pkg::RST_MIN_SPEED);
    regs[kcsc_pkg::REG_MAX_SPEED]    = 16'(kcsc_pkg::RST_MAX_SPEED);
    regs[kcsc_pkg::REG_READY_PER]    = kcsc_pkg::RST_PERIOD;
    regs[kcsc_pkg::REG_CHARGING_PER] = kcsc_pkg::RST_PERIOD;
    regs[kcsc_pkg::REG_SHOOTING_PER] = kcsc_pkg::RST_PERIOD;
    regs[kcsc_pkg::REG_OFF_PER]      = kcsc_pkg::RST_PERIOD;
    return regs;
  endfunction

  // Upper nibble set on some of the 12-bit registers: the block must drop it.
  function automatic reg_set_t extreme_settings(input bit wide_window);
    reg_set_t regs;
    if (wide_window) begin
      // every voltage in the window; speed limits crossed; zero charging and off periods
      regs[kcsc_pkg::REG_MIN_SHOOT_V]  = 16'h0000;
      regs[kcsc_pkg::REG_RECHARGE_V]   = 16'hFFFF;
      regs[kcsc_pkg::REG_MIN_SPEED]    = 16'hFFFF;
      regs[kcsc_pkg::REG_MAX_SPEED]    = 16'hF000;
      regs[kcsc_pkg::REG_READY_PER]    = 16'd1;
      regs[kcsc_pkg::REG_CHARGING_PER] = 16'd0;
      regs[kcsc_pkg::REG_SHOOTING_PER] = 16'hFFFF;
      regs[kcsc_pkg::REG_OFF_PER]      = 16'd0;
    end else begin
      // empty voltage window; full speed range
      regs[kcsc_pkg::REG_MIN_SHOOT_V]  = 16'h0FFF;
      regs[kcsc_pkg::REG_RECHARGE_V]   = 16'hF000;
      regs[kcsc_pkg::REG_MIN_SPEED]    = 16'h0000;
      regs[kcsc_pkg::REG_MAX_SPEED]    = 16'h0FFF;
      regs[kcsc_pkg::REG_READY_PER]    = 16'hFFFF;
      regs[kcsc_pkg::REG_CHARGING_PER] = 16'd1;
      regs[kcsc_pkg::REG_SHOOTING_PER] = 16'd1;
      regs[kcsc_pkg::REG_OFF_PER]      = 16'hFFFF;
    end
    return regs;
  endfunction

  task automatic test_power_on();
    do_callback(32'd0, 12'd0, 1'b0, 1'b1, 1'b1);
    do_command(kcsc_pkg::FN_SHOOT, 1'b0, 12'd0);          // raised to min speed
    do_callback(32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b1, 1'b1);
    do_command(kcsc_pkg::FN_SHOOT, 1'b1, 12'd4095);       // lowered to max speed
    do_command(kcsc_pkg::FN_DISABLE, 1'b0, 12'd100);
    do_command(kcsc_pkg::FN_SHOOT, 1'b0, 12'd100);        // ignored while shooting
    do_callback(32'd500, 12'd4095, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_charge_cycle();
    do_command(kcsc_pkg::FN_START, 1'b0, 12'd0);
    do_callback(32'd900, 12'd100, 1'b1, 1'b1, 1'b1);
    do_command(kcsc_pkg::FN_SHOOT, 1'b1, 12'd800);        // ignored while charging
    do_callback(32'd1000, 12'd2500, 1'b1, 1'b1, 1'b0);
    do_callback(32'd1100, 12'd399, 1'b1, 1'b1, 1'b1);
    do_callback(32'd1200, 12'd2201, 1'b1, 1'b1, 1'b1);
    do_callback(32'd1300, 12'd400, 1'b1, 1'b1, 1'b1);
    do_callback(32'd3000, 12'd2500, 1'b1, 1'b1, 1'b0);
    do_callback(32'd3100, 12'd2200, 1'b1, 1'b1, 1'b1);
    do_command(kcsc_pkg::FN_DISABLE, 1'b0, 12'd0);
    // sensor down: recharge only after the ready timeout
    do_callback(32'd17999, 12'd1000, 1'b0, 1'b1, 1'b1);
    do_callback(32'd18000, 12'd1000, 1'b0, 1'b1, 1'b1);
    do_command(kcsc_pkg::FN_START, 1'b0, 12'd0);
    // ready near the top of the counter: the deadline wraps
    do_callback(32'hFFFF_FF00, 12'd3000, 1'b1, 1'b1, 1'b0);
    do_callback(32'hFFFF_FF10, 12'd3000, 1'b0, 1'b1, 1'b1);
    do_callback(32'hFFFF_FF20, 12'd3000, 1'b1, 1'b1, 1'b0);
    do_command(kcsc_pkg::FN_SHOOT, 1'b0, 12'd2048);
    do_callback(32'hFFFF_FF30, 12'd3000, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_config_extremes();
    apply_settings(extreme_settings(1'b1));
    do_command(kcsc_pkg::FN_DISABLE, 1'b0, 12'd0);
    do_callback(32'd40, 12'd0, 1'b1, 1'b1, 1'b1);
    do_callback(32'd50, 12'd0, 1'b1, 1'b1, 1'b0);
    do_command(kcsc_pkg::FN_SHOOT, 1'b1, 12'd2048);
    do_callback(32'd60, 12'd0, 1'b1, 1'b1, 1'b1);
    do_callback(32'd70, 12'd0, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic run_random_phase(input int n_items, input int gap, input int stall);
    kick_event_t ev;
    int          pick;
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      ev.func        = kcsc_pkg::func_t'($urandom_range(3));
      ev.now_ms      = $urandom();
      ev.cap_voltage = 12'($urandom());
      {ev.sensor_ok, ev.charge_done_n, ev.shot_kind} = 3'($urandom());
      ev.fault_n     = 1'b1;  // faults are sticky: kept for the last test
      ev.ball_speed  = 12'($urandom());
      pick = $urandom_range(99);
      if (pick >= 20) begin
        // well-formed flow steered by the predicted phase
        case (mdl_phase)
          kcsc_pkg::PH_OFF: begin
            ev.func = pick < 55 ? kcsc_pkg::FN_START :
                      pick < 80 ? kcsc_pkg::FN_SHOOT : kcsc_pkg::FN_CALLBACK;
          end
          kcsc_pkg::PH_CHARGING: begin
            ev.func = pick < 88 ? kcsc_pkg::FN_CALLBACK :
                      pick < 95 ? kcsc_pkg::FN_DISABLE : kcsc_pkg::FN_SHOOT;
            ev.charge_done_n = ($urandom_range(3) != 0);
          end
          kcsc_pkg::PH_READY: begin
            ev.func = pick < 60 ? kcsc_pkg::FN_CALLBACK :
                      pick < 85 ? kcsc_pkg::FN_SHOOT :
                      pick < 93 ? kcsc_pkg::FN_DISABLE : kcsc_pkg::FN_START;
            ev.sensor_ok = ($urandom_range(7) != 0);
            if (lim_min_shoot <= lim_recharge && $urandom_range(1) == 1)
              ev.cap_voltage = 12'($urandom_range(lim_recharge, lim_min_shoot));
          end
          default: begin
            if (pick < 85) ev.func = kcsc_pkg::FN_CALLBACK;
          end
        endcase
        if (ev.func == kcsc_pkg::FN_CALLBACK) begin
          clock_ms  = clock_ms + $urandom_range(6000);
          ev.now_ms = clock_ms;
        end
      end else if (ev.func == kcsc_pkg::FN_CALLBACK) begin
        clock_ms = ev.now_ms;
      end
      send_event(ev);
      // hold off now and then until the controller has answered everything
      if (i == n_items / 2 || $urandom_range(199) == 0) wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    reg_set_t regs;
    int       gap;
    int       stall;
    for (int n = 0; n < 12; n++) begin
      case (n % 3)
        0: for (int i = 0; i < 8; i++) regs[i] = 16'($urandom());
        1: regs = extreme_settings((n / 3) % 2 == 1);
        default: regs = default_settings();
      endcase
      apply_settings(regs);
      case (n / 3)
        0: begin gap = 0;  stall = 0;  end
        1: begin gap = 45; stall = 0;  end
        2: begin gap = 0;  stall = 45; end
        default: begin gap = 15; stall = 15; end
      endcase
      run_random_phase(150, gap, stall);
    end
  endtask

  task automatic test_sticky_fault();
    apply_settings(default_settings());
    gap_pct   = 15;
    stall_pct = 15;
    do_callback(clock_ms, 12'd1000, 1'b1, 1'b0, 1'b1);
    do_callback(clock_ms + 32'd10, 12'd1000, 1'b1, 1'b1, 1'b1);
    do_command(kcsc_pkg::FN_START, 1'b0, 12'd0);
    do_callback(clock_ms + 32'd20, 12'd1000, 1'b1, 1'b1, 1'b0);
    do_command(kcsc_pkg::FN_SHOOT, 1'b1, 12'd1000);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on();
    test_charge_cycle();
    test_config_extremes();
    test_random_traffic();
    test_sticky_fault();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kcsc_pkg.sv
rtl/kcsc_ctrl.sv
rtl/kcsc_dp.sv
rtl/kicker_charge_shoot_controller_unit.sv
tb/kicker_charge_shoot_controller_unit_test.sv
